### rtl/bcrs_pkg.sv
// Shared constants for the bisection cube root solver: register indexes,
// reset values, result status codes and field widths.
// No dependencies.
`default_nettype none

package bcrs_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_STEPS_DEF = 40;
	localparam int FRAC_BITS_DEF = 28;

	// Field widths
	localparam int X_W        = 32;   // endpoint and root width
	localparam int STEP_OUT_W = 7;    // step_count field
	localparam int STATUS_W   = 3;    // result_status field
	localparam int F_W        = 64;   // f(x) in units of 2^-40
	localparam int CUBE_W     = 96;   // exact magnitude of x^3
	localparam int CUBE_MAG_W = 61;   // saturated cube magnitude
	localparam int K_SHIFT    = 40;   // k is scaled by 2^40

	// Stream payload widths
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 48;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int K_W        = 8;
	localparam int TOL_W      = 24;

	localparam logic [CFG_IDX_W-1:0] REG_CUBE_OFFSET    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_TOL       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONVERGE_TOL   = 2'd2;

	localparam logic [K_W-1:0]   CUBE_OFFSET_RST  = 8'd2;
	localparam logic [TOL_W-1:0] ROOT_TOL_RST     = 24'd1100;
	localparam logic [TOL_W-1:0] CONVERGE_TOL_RST = 24'd109951;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_CONVERGED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_END_B_ROOT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_END_A_ROOT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MID_ROOT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_SIGN    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_STEP_LIMIT = 3'd5;

endpackage

`default_nettype wire

### rtl/bisection_cube_root_solver_unit.sv
// Bisection root finder for f(x) = x^3 - k, fixed point, one shared multiplier.
// Depends on bcrs_pkg.
// Usage:
//  - Input stream (s_axis_*): one item holds the interval endpoints end_a and
//    end_b, signed Q4.28 by default. s_axis_tready is high only while the
//    solver is idle; an item is taken when tvalid and tready are both high.
//  - Output stream (m_axis_*): exactly one item per input: root_value,
//    step_count and result_status. The result sits in an output register and
//    holds while m_axis_tready is low; the solver can take the next input item
//    while that result still waits, but it will not finish a new one until
//    the register is free.
//  - Configuration (cfg_we, cfg_index, cfg_data): k, root tolerance and
//    convergence tolerance; write only while the solver is idle.
//  - Evaluation: each f(x) evaluation runs on the single 32x32 multiplier
//    through magnitude, square, two partial products of the cube, scale
//    and subtract k; each halving evaluates f at the midpoint, then picks
//    a half and tests for convergence. At most MAX_STEPS halvings are run
//    per item.
//  - Reset (arst_n low) returns the solver to idle, drops any pending result
//    and restores the configuration registers to their defaults.
`default_nettype none

module bisection_cube_root_solver_unit #(
	parameter int MAX_STEPS = bcrs_pkg::MAX_STEPS_DEF,
	parameter int FRAC_BITS = bcrs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Input stream
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [bcrs_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // end_a[31:0], end_b[63:32]
	// Output stream
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [bcrs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // root_value[31:0],
	                                                            // step_count[38:32],
	                                                            // result_status[41:39], zero
	// Configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [bcrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bcrs_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int STEP_W     = $clog2(MAX_STEPS + 1);
	localparam int CUBE_SHIFT = 3 * FRAC_BITS - bcrs_pkg::K_SHIFT;
	localparam int X_W        = bcrs_pkg::X_W;
	localparam int F_W        = bcrs_pkg::F_W;
	localparam int CUBE_W     = bcrs_pkg::CUBE_W;
	localparam int MAG_W      = bcrs_pkg::CUBE_MAG_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EV_MAG,
		S_EV_SQ,
		S_EV_LO,
		S_EV_HI,
		S_EV_CUBE,
		S_EV_F,
		S_ENDS,
		S_TEST,
		S_PICK,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_C
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	// Configuration registers
	logic [bcrs_pkg::K_W-1:0]   cube_offset_q;
	logic [bcrs_pkg::TOL_W-1:0] root_tol_q;
	logic [bcrs_pkg::TOL_W-1:0] conv_tol_q;

	// Interval, evaluation point and function values
	logic signed [X_W-1:0] a_q, b_q, x_q;
	logic signed [F_W-1:0] fa_q, fb_q, fc_q;
	logic [STEP_W-1:0]     steps_q;

	// Cube datapath
	logic                  neg_q;
	logic [X_W-1:0]        m_q;
	logic [2*X_W-1:0]      p_q, lp_q, hp_q;
	logic [MAG_W-1:0]      cube_q;

	// Pending result
	logic signed [X_W-1:0]               res_root_q;
	logic [bcrs_pkg::STATUS_W-1:0]       res_status_q;

	// Combinational signals
	logic [X_W-1:0]        mul_a;
	logic [2*X_W-1:0]      prod;
	logic [CUBE_W-1:0]     cube_sum, cube_shr;
	logic [MAG_W-1:0]      cube_mag;
	logic signed [F_W-1:0] cube_s, koff, f_new, fdiff;
	logic signed [F_W-1:0] rtol, ctol;
	logic                  fa_ok, fb_ok, fc_ok;
	logic                  opp_ac, opp_bc, reject, conv_big;
	logic [X_W:0]          mid_sum;
	logic signed [X_W-1:0] mid;

	assign s_axis_tready = (state_q == S_IDLE);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cube_offset_q <= bcrs_pkg::CUBE_OFFSET_RST;
			root_tol_q    <= bcrs_pkg::ROOT_TOL_RST;
			conv_tol_q    <= bcrs_pkg::CONVERGE_TOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcrs_pkg::REG_CUBE_OFFSET:  cube_offset_q <= cfg_data[bcrs_pkg::K_W-1:0];
				bcrs_pkg::REG_ROOT_TOL:     root_tol_q    <= cfg_data[bcrs_pkg::TOL_W-1:0];
				bcrs_pkg::REG_CONVERGE_TOL: conv_tol_q    <= cfg_data[bcrs_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Select the multiplier operand; the other one is always |x|
	always_comb begin
		unique case (state_q)
			S_EV_LO: mul_a = p_q[X_W-1:0];
			S_EV_HI: mul_a = p_q[2*X_W-1:X_W];
			default: mul_a = m_q;
		endcase
	end

	assign prod = mul_a * m_q;

	// Assemble |x|^3, scale to 2^-40 units and saturate
	assign cube_sum = {hp_q, {X_W{1'b0}}} + {{X_W{1'b0}}, lp_q};
	assign cube_shr = cube_sum >> CUBE_SHIFT;
	assign cube_mag = (|cube_shr[CUBE_W-1:MAG_W]) ? {MAG_W{1'b1}} : cube_shr[MAG_W-1:0];

	// Apply sign and subtract k * 2^40
	assign cube_s = neg_q ? -$signed({{(F_W-MAG_W){1'b0}}, cube_q})
	                      :  $signed({{(F_W-MAG_W){1'b0}}, cube_q});
	assign koff   = $signed({{(F_W-bcrs_pkg::K_W-bcrs_pkg::K_SHIFT){1'b0}}, cube_offset_q,
	                         {bcrs_pkg::K_SHIFT{1'b0}}});
	assign f_new  = cube_s - koff;

	// Tolerance tests without forming |f|
	assign rtol  = $signed({{(F_W-bcrs_pkg::TOL_W){1'b0}}, root_tol_q});
	assign ctol  = $signed({{(F_W-bcrs_pkg::TOL_W){1'b0}}, conv_tol_q});
	assign fa_ok = (fa_q <= rtol) && (fa_q >= -rtol);
	assign fb_ok = (fb_q <= rtol) && (fb_q >= -rtol);
	assign fc_ok = (fc_q <= rtol) && (fc_q >= -rtol);

	// Strict sign changes
	assign opp_ac = (fa_q != '0) && (fc_q != '0) && (fa_q[F_W-1] ^ fc_q[F_W-1]);
	assign opp_bc = (fb_q != '0) && (fc_q != '0) && (fb_q[F_W-1] ^ fc_q[F_W-1]);
	assign reject = (fa_q != '0) && (fb_q != '0) && (fa_q[F_W-1] == fb_q[F_W-1])
	                && !fa_ok && !fb_ok;

	// Convergence: |f(a) - f(b)| >= tolerance keeps the search going
	assign fdiff    = fa_q - fb_q;
	assign conv_big = !((fdiff < ctol) && (fdiff > -ctol));

	// Floor midpoint of the interval
	assign mid_sum = {a_q[X_W-1], a_q} + {b_q[X_W-1], b_q};
	assign mid     = $signed(mid_sum[X_W:1]);

	// Sequencer, datapath registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_A;
			steps_q       <= '0;
			a_q           <= '0;
			b_q           <= '0;
			x_q           <= '0;
			fa_q          <= '0;
			fb_q          <= '0;
			fc_q          <= '0;
			neg_q         <= 1'b0;
			m_q           <= '0;
			p_q           <= '0;
			lp_q          <= '0;
			hp_q          <= '0;
			cube_q        <= '0;
			res_root_q    <= '0;
			res_status_q  <= bcrs_pkg::ST_CONVERGED;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			// Drop the result once the receiver takes it; S_OUT reloads it itself
			if (m_axis_tvalid && m_axis_tready && state_q != S_OUT)
				m_axis_tvalid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						a_q     <= $signed(s_axis_tdata[X_W-1:0]);
						b_q     <= $signed(s_axis_tdata[2*X_W-1:X_W]);
						x_q     <= $signed(s_axis_tdata[X_W-1:0]);
						phase_q <= PH_A;
						steps_q <= '0;
						state_q <= S_EV_MAG;
					end
				end
				S_EV_MAG: begin
					neg_q   <= x_q[X_W-1];
					m_q     <= x_q[X_W-1] ? X_W'(-x_q) : X_W'(x_q);
					state_q <= S_EV_SQ;
				end
				S_EV_SQ: begin
					p_q     <= prod;
					state_q <= S_EV_LO;
				end
				S_EV_LO: begin
					lp_q    <= prod;
					state_q <= S_EV_HI;
				end
				S_EV_HI: begin
					hp_q    <= prod;
					state_q <= S_EV_CUBE;
				end
				S_EV_CUBE: begin
					cube_q  <= cube_mag;
					state_q <= S_EV_F;
				end
				S_EV_F: begin
					unique case (phase_q)
						PH_A: begin
							fa_q    <= f_new;
							x_q     <= b_q;
							phase_q <= PH_B;
							state_q <= S_EV_MAG;
						end
						PH_B: begin
							fb_q    <= f_new;
							state_q <= S_ENDS;
						end
						default: begin
							fc_q    <= f_new;
							state_q <= S_PICK;
						end
					endcase
				end
				S_ENDS: begin
					if (reject) begin
						res_root_q   <= '0;
						res_status_q <= bcrs_pkg::ST_NO_SIGN;
						state_q      <= S_OUT;
					end else if (fb_ok) begin
						res_root_q   <= b_q;
						res_status_q <= bcrs_pkg::ST_END_B_ROOT;
						state_q      <= S_OUT;
					end else if (fa_ok) begin
						res_root_q   <= a_q;
						res_status_q <= bcrs_pkg::ST_END_A_ROOT;
						state_q      <= S_OUT;
					end else begin
						state_q      <= S_TEST;
					end
				end
				S_TEST: begin
					if (!conv_big) begin
						res_root_q   <= mid;
						res_status_q <= bcrs_pkg::ST_CONVERGED;
						state_q      <= S_OUT;
					end else if (steps_q >= STEP_W'(MAX_STEPS)) begin
						res_root_q   <= mid;
						res_status_q <= bcrs_pkg::ST_STEP_LIMIT;
						state_q      <= S_OUT;
					end else begin
						// Advance to the next halving
						steps_q <= steps_q + 1'b1;
						x_q     <= mid;
						phase_q <= PH_C;
						state_q <= S_EV_MAG;
					end
				end
				S_PICK: begin
					if (opp_ac) begin
						b_q     <= x_q;
						fb_q    <= fc_q;
						state_q <= S_TEST;
					end else if (opp_bc) begin
						a_q     <= x_q;
						fa_q    <= fc_q;
						state_q <= S_TEST;
					end else if (fc_ok) begin
						res_root_q   <= x_q;
						res_status_q <= bcrs_pkg::ST_MID_ROOT;
						state_q      <= S_OUT;
					end else begin
						// Stalled halving: keep the interval, the count still advances
						state_q <= S_TEST;
					end
				end
				S_OUT: begin
					// Load the output register once it is free
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {{(bcrs_pkg::OUT_DATA_W - X_W - bcrs_pkg::STEP_OUT_W
						                    - bcrs_pkg::STATUS_W){1'b0}},
						                  res_status_q,
						                  bcrs_pkg::STEP_OUT_W'(steps_q),
						                  res_root_q};
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
